@@ hdl/slfp_pkg.sv @@
// ----------------------------------------------------------------------------
// slfp_pkg
// Shared types and constants for the sync/type/length frame parser.
// ----------------------------------------------------------------------------
package slfp_pkg;

	localparam int MAX_PAYLOAD_DEF = 256;
	localparam int OUT_DEPTH       = 4;

	localparam logic [7:0] SYNC_RESET = 8'hAD;

	localparam logic [1:0] OP_PUSH   = 2'd0;
	localparam logic [1:0] OP_ABORT  = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic RK_FRAME = 1'b0;
	localparam logic RK_READ  = 1'b1;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] data_byte;
		logic [7:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] type_code;
		logic [8:0] frame_length;
		logic [7:0] read_data;
	} out_item_t;

	// Result descriptor handed from the parser control to the output side.
	typedef struct packed {
		logic       kind;
		logic [7:0] type_code;
		logic [8:0] frame_length;
		logic       idx_ok;
	} res_info_t;

endpackage

@@ hdl/sync_length_frame_parser.sv @@
// ----------------------------------------------------------------------------
// sync_length_frame_parser
// Byte-stream deframer: sync byte, type byte, 16-bit big-endian length and
// payload, with abort and payload read-back requests.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  cfg       in         cfg_valid/cfg_ready    cfg_data (sync byte)
//  in        in         in_valid/in_ready      in_data (in_item_t)
//  out       out        out_valid/out_ready    out_data (out_item_t)
//
// One request is accepted per clock while the queue has room; a result is
// registered in the read stage, where the payload buffer read is registered
// beside its descriptor, and then in the output queue before it leaves. The
// sustained rate is one request a cycle, limited by room in the four-entry
// result queue. Reset clears the header state and the queue at once; the
// payload buffer needs no clearing pass. When out_ready is held low,
// in_ready falls once the queue and the read stage together are full.
// ----------------------------------------------------------------------------
module sync_length_frame_parser #(
	parameter int MAX_PAYLOAD = slfp_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  slfp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output slfp_pkg::out_item_t out_data
);
	import slfp_pkg::*;

	// Buffer address width, kept at least one bit for a single-entry buffer.
	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	// Count width, able to hold MAX_PAYLOAD itself.
	localparam int CW = $clog2(MAX_PAYLOAD + 1);
	localparam int QW = $clog2(OUT_DEPTH) + 1;

	logic [7:0]    sync_q;
	logic          in_fire;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata, mem_rdata;
	logic          res_valid_s1;
	res_info_t     res_s1;
	out_item_t     push_item;
	logic [QW-1:0] q_count;
	logic          pop;

	// The sync byte register may be written whenever the block is idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			sync_q <= cfg_data;
		end
	end

	// Admit a request only when the queue can hold its result together with
	// the one that may already sit in the read stage.
	assign in_ready = (q_count + QW'(res_valid_s1)) < QW'(OUT_DEPTH);
	assign in_fire  = in_valid && in_ready;

	slfp_ctrl #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.AW(AW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_fire(in_fire),
		.in_item(in_data),
		.sync_byte(sync_q),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.res_valid_s1(res_valid_s1),
		.res_s1(res_s1)
	);

	slfp_store #(
		.DEPTH(MAX_PAYLOAD),
		.AW(AW)
	) u_store (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// The buffer data arrives alongside the registered descriptor. A read
	// beyond the buffer answers zero, as does the data field of a frame result.
	always_comb begin
		push_item.result_kind  = res_s1.kind;
		push_item.type_code    = res_s1.type_code;
		push_item.frame_length = res_s1.frame_length;
		push_item.read_data    = (res_s1.kind == RK_READ && res_s1.idx_ok) ? mem_rdata : 8'd0;
	end

	assign pop = out_valid && out_ready;

	slfp_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_valid_s1),
		.push_item(push_item),
		.pop(pop),
		.not_empty(out_valid),
		.head(out_data),
		.count(q_count)
	);

	// A request is never admitted when the queue would have no room for it.
	a_admit_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> (q_count + QW'(res_valid_s1)) < QW'(OUT_DEPTH))
		else $error("request admitted without queue room");

endmodule

@@ hdl/slfp_store.sv @@
// ----------------------------------------------------------------------------
// slfp_store
// Payload buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module slfp_store #(
	parameter int DEPTH = slfp_pkg::MAX_PAYLOAD_DEF,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/slfp_ctrl.sv @@
// ----------------------------------------------------------------------------
// slfp_ctrl
// Frame state machine: tracks the header, issues buffer writes and reads,
// and registers one result descriptor per request that produces a result.
// ----------------------------------------------------------------------------
module slfp_ctrl #(
	parameter int MAX_PAYLOAD = slfp_pkg::MAX_PAYLOAD_DEF,
	parameter int AW          = 8,
	parameter int CW          = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	input  slfp_pkg::in_item_t   in_item,
	input  logic [7:0]           sync_byte,
	output logic                 mem_we,
	output logic [AW-1:0]        mem_waddr,
	output logic [7:0]           mem_wdata,
	output logic                 mem_re,
	output logic [AW-1:0]        mem_raddr,
	output logic                 res_valid_s1,
	output slfp_pkg::res_info_t  res_s1
);
	import slfp_pkg::*;

	localparam logic [2:0] PH_HUNT   = 3'd0;
	localparam logic [2:0] PH_TYPE   = 3'd1;
	localparam logic [2:0] PH_LEN_HI = 3'd2;
	localparam logic [2:0] PH_LEN_LO = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;

	logic [2:0]    phase_q, phase_d;
	logic [7:0]    type_q, type_d;
	logic [7:0]    len_hi_q, len_hi_d;
	logic [CW-1:0] len_q, len_d;
	logic [CW-1:0] count_q, count_d;
	logic [15:0]   full_len;
	logic          res_valid;
	res_info_t     res;

	assign full_len  = {len_hi_q, in_item.data_byte};
	assign mem_wdata = in_item.data_byte;
	assign mem_raddr = AW'(in_item.read_index);
	assign mem_waddr = AW'(count_q);

	always_comb begin
		phase_d   = phase_q;
		type_d    = type_q;
		len_hi_d  = len_hi_q;
		len_d     = len_q;
		count_d   = count_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		res_valid = 1'b0;
		res       = '{kind: RK_FRAME, type_code: type_q, frame_length: 9'd0, idx_ok: 1'b0};
		if (in_fire) begin
			unique case (in_item.opcode)
				OP_PUSH: begin
					unique case (phase_q)
						PH_TYPE: begin
							type_d  = in_item.data_byte;
							phase_d = PH_LEN_HI;
						end
						PH_LEN_HI: begin
							len_hi_d = in_item.data_byte;
							phase_d  = PH_LEN_LO;
						end
						PH_LEN_LO: begin
							if (full_len == 16'd0) begin
								phase_d   = PH_HUNT;
								res_valid = 1'b1;
							end else if (32'(full_len) > MAX_PAYLOAD) begin
								phase_d = PH_HUNT;
							end else begin
								len_d   = CW'(full_len);
								count_d = '0;
								phase_d = PH_DATA;
							end
						end
						PH_DATA: begin
							mem_we  = 1'b1;
							count_d = count_q + CW'(1);
							if (count_d >= len_q) begin
								phase_d          = PH_HUNT;
								res_valid        = 1'b1;
								res.frame_length = 9'(len_q);
							end
						end
						default: begin
							phase_d = (in_item.data_byte == sync_byte) ? PH_TYPE : PH_HUNT;
						end
					endcase
				end
				OP_ABORT: begin
					phase_d = PH_HUNT;
				end
				OP_READ: begin
					mem_re     = 1'b1;
					res_valid  = 1'b1;
					res.kind   = RK_READ;
					res.type_code = 8'd0;
					res.idx_ok = 32'(in_item.read_index) < MAX_PAYLOAD;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			type_q       <= '0;
			len_hi_q     <= '0;
			len_q        <= '0;
			count_q      <= '0;
			res_valid_s1 <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			type_q       <= type_d;
			len_hi_q     <= len_hi_d;
			len_q        <= len_d;
			count_q      <= count_d;
			res_valid_s1 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		res_s1 <= res;
	end

	// The buffer is never written and read by the same request.
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("buffer write and read issued together");

	// A read request always yields a read result in the following cycle.
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> (res_valid_s1 && res_s1.kind == RK_READ))
		else $error("read request lost its result");

endmodule

@@ hdl/slfp_outq.sv @@
// ----------------------------------------------------------------------------
// slfp_outq
// Small result queue between the buffer read stage and the output channel.
// ----------------------------------------------------------------------------
module slfp_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  slfp_pkg::out_item_t push_item,
	input  logic                pop,
	output logic                not_empty,
	output slfp_pkg::out_item_t head,
	output logic [$clog2(slfp_pkg::OUT_DEPTH):0] count
);
	import slfp_pkg::*;

	localparam int PW = $clog2(OUT_DEPTH);

	out_item_t      slots_q [OUT_DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [PW:0]    count_q;

	assign not_empty = (count_q != '0);
	assign head      = slots_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	// Upstream admission must keep the queue from overflowing.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && count_q == (PW+1)'(OUT_DEPTH)))
		else $error("result queue overflow");

endmodule
